// ===== rtl/core/cluster_head_table_merge_unit_defines.svh =====
// assertion macros for the cluster head table merge unit
`ifndef CLUSTER_HEAD_TABLE_MERGE_UNIT_DEFINES_SVH
`define CLUSTER_HEAD_TABLE_MERGE_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CHTM_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define CHTM_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/chtm_pkg.sv =====
package chtm_pkg;
    localparam int unsigned TableDepthDef = 16;
    localparam int unsigned IdW = 8;
    localparam int unsigned HopW = 8;
    localparam int unsigned StW = 2;
    localparam int unsigned CntW = 5;

    typedef enum logic [1:0] {
        CMD_ENTRY  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] KIND_MERGE  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    typedef struct packed {
        logic [StW-1:0]  status;
        logic [HopW-1:0] hops;
        logic [IdW-1:0]  id;
    } entry_t;
endpackage

// ===== rtl/core/cluster_head_table_merge_unit.sv =====
// Cluster-head table merge: keeps a table of up to TABLE_DEPTH entries sorted by id.
// A received entry item (command 0) is buffered in the accepting cycle. On the item
// marked last the buffer is merged into the table through a single compare unit, with a
// read and a compare state per walk step, at most local_count + received_count steps,
// and one more read and compare to close the walk, then a copy back through a read and
// a write state per merged entry and a result state. Insert searches the table with a
// read and a compare state per entry and shifts larger entries up with a read and a
// write state per entry. Dump reads and emits one entry at a time while the result side
// is ready. The input is not ready while an item is in progress or while its result
// still waits in the one result register on the output.
`include "cluster_head_table_merge_unit_defines.svh"
module cluster_head_table_merge_unit
    import chtm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = chtm_pkg::TableDepthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,        // own_node_id
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: entry_id[7:0], entry_hops[15:8], entry_status[17:16], zero
    input  logic [23:0] s_tdata,
    // tuser: command[1:0], list_empty[2]
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,          // entry_last
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: out_id[7:0], out_hops[15:8], out_status[17:16], changed[18],
    //        table_count[23:19]
    output logic [23:0] m_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast           // out_last
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MRD, ST_MCMP, ST_CPRD, ST_CPWR, ST_IRD, ST_ICMP,
        ST_SHRD, ST_SHWR, ST_IWR, ST_DRD, ST_DOUT, ST_RES
    } state_t;

    state_t state_reg;
    logic [7:0]  own_reg;
    logic [CW-1:0] lcnt_reg, rcnt_reg, i_reg, j_reg, m_reg;
    logic        delta_reg;
    logic [StW-1:0] ist_reg;
    logic        ovalid_reg, olast_reg, ochg_reg;
    logic [1:0]  okind_reg;
    entry_t      oent_reg;
    logic [CW-1:0] ocnt_reg;

    // storage: local table, received buffer, merge scratch
    entry_t ltab [TABLE_DEPTH];
    entry_t rbuf [TABLE_DEPTH];
    entry_t mtab [TABLE_DEPTH];
    entry_t lrd_reg, rrd_reg, mrd_reg;

    logic        lwe, rwe, mwe;
    logic [AW-1:0] lwa, rwa, mwa, lra, rra, mra;
    entry_t      lwd, rwd, mwd;

    always_ff @(posedge aclk) begin
        if (lwe) ltab[lwa] <= lwd;
        if (rwe) rbuf[rwa] <= rwd;
        if (mwe) mtab[mwa] <= mwd;
        lrd_reg <= ltab[lra];
        rrd_reg <= rbuf[rra];
        mrd_reg <= mtab[mra];
    end

    entry_t in_ent;
    logic   s_acc, m_acc, s_empty;
    assign in_ent = '{status: s_tdata[17:16], hops: s_tdata[15:8], id: s_tdata[7:0]};
    assign s_empty = s_tuser[2];
    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // merge compare unit
    logic i_more, j_more, take_r, take_l;
    entry_t pick;
    assign i_more = i_reg < lcnt_reg;
    assign j_more = j_reg < rcnt_reg;
    assign take_r = !i_more || (j_more && rrd_reg.id < lrd_reg.id);
    assign take_l = !take_r && (!j_more || rrd_reg.id > lrd_reg.id);
    always_comb begin
        pick = take_r ? rrd_reg : (take_l ? lrd_reg : rrd_reg);
        if (!take_r && !take_l && lrd_reg.hops < rrd_reg.hops) pick.hops = lrd_reg.hops;
    end

    // memory ports
    always_comb begin
        lwe = 1'b0; rwe = 1'b0; mwe = 1'b0;
        lwa = i_reg[AW-1:0]; rwa = rcnt_reg[AW-1:0]; mwa = m_reg[AW-1:0];
        lwd = mrd_reg; rwd = in_ent; mwd = pick;
        lra = i_reg[AW-1:0]; rra = j_reg[AW-1:0]; mra = i_reg[AW-1:0];
        case (state_reg)
            ST_IDLE: rwe = s_acc && s_tuser[1:0] == CMD_ENTRY && !s_empty && rcnt_reg < DepthC;
            ST_MCMP: mwe = (i_more || j_more) && m_reg < DepthC;
            ST_CPWR: lwe = 1'b1;
            ST_SHRD: lra = AW'(i_reg - 1'b1);
            ST_SHWR: begin
                lwe = 1'b1;
                lwd = lrd_reg;
            end
            ST_IWR: begin
                lwe = 1'b1;
                lwd = '{status: ist_reg, hops: '0, id: own_reg};
            end
            default: ;
        endcase
    end

    logic [7:0] hinc;
    assign hinc = (lrd_reg.hops == 8'hFF) ? 8'hFF : lrd_reg.hops + 8'd1;

    // result register load
    logic oload;
    assign oload = (state_reg == ST_DOUT || state_reg == ST_RES) && (!ovalid_reg || m_acc);

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; own_reg <= '0; lcnt_reg <= '0; rcnt_reg <= '0;
            ovalid_reg <= 1'b0; i_reg <= '0; j_reg <= '0; m_reg <= '0; delta_reg <= 1'b0;
        end else begin
            if (cfg_we) own_reg <= cfg_wdata;
            if (oload) ovalid_reg <= 1'b1;
            else if (m_acc) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_acc) begin
                    i_reg <= '0; j_reg <= '0; m_reg <= '0; delta_reg <= 1'b0;
                    ist_reg <= s_tdata[17:16];
                    case (cmd_t'(s_tuser[1:0]))
                        CMD_ENTRY: begin
                            if (!s_empty && rcnt_reg < DepthC) rcnt_reg <= rcnt_reg + 1'b1;
                            if (s_tlast) state_reg <= ST_MRD;
                        end
                        CMD_INSERT: state_reg <= ST_IRD;
                        CMD_DUMP: if (lcnt_reg != '0) state_reg <= ST_DRD;
                        default: ;
                    endcase
                end
                ST_MRD: state_reg <= ST_MCMP;
                ST_MCMP: begin
                    if (!i_more && !j_more) begin
                        i_reg <= '0; rcnt_reg <= '0;
                        state_reg <= (m_reg == '0) ? ST_RES : ST_CPRD;
                    end else begin
                        if (m_reg < DepthC) m_reg <= m_reg + 1'b1;
                        if (take_r) begin j_reg <= j_reg + 1'b1; delta_reg <= 1'b1; end
                        else if (take_l) begin i_reg <= i_reg + 1'b1; delta_reg <= 1'b1; end
                        else begin i_reg <= i_reg + 1'b1; j_reg <= j_reg + 1'b1; end
                        state_reg <= ST_MRD;
                    end
                end
                ST_CPRD: state_reg <= ST_CPWR;
                ST_CPWR: begin
                    i_reg <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == m_reg) ? ST_RES : ST_CPRD;
                end
                ST_IRD: state_reg <= (i_reg < lcnt_reg) ? ST_ICMP : ST_SHRD;
                ST_ICMP: begin
                    if (lrd_reg.id == own_reg) begin
                        state_reg <= ST_RES;
                    end else begin
                        if (lrd_reg.id > own_reg && !delta_reg) begin
                            delta_reg <= 1'b1; j_reg <= i_reg;
                        end
                        i_reg <= i_reg + 1'b1;
                        state_reg <= ST_IRD;
                    end
                end
                ST_SHRD: begin
                    // j_reg holds the slot, lcnt when none larger
                    if (lcnt_reg >= DepthC) state_reg <= ST_RES;
                    else if (!delta_reg) begin j_reg <= lcnt_reg; delta_reg <= 1'b1;
                        i_reg <= lcnt_reg; state_reg <= ST_IWR; end
                    else if (i_reg == j_reg) state_reg <= ST_IWR;
                    else state_reg <= ST_SHWR;
                end
                ST_SHWR: begin i_reg <= i_reg - 1'b1; state_reg <= ST_SHRD; end
                ST_IWR: begin lcnt_reg <= lcnt_reg + 1'b1; m_reg <= lcnt_reg + 1'b1;
                    delta_reg <= 1'b1; state_reg <= ST_RES; end
                ST_DRD: state_reg <= ST_DOUT;
                ST_DOUT: if (!ovalid_reg || m_acc) begin
                    okind_reg <= KIND_DUMP; ochg_reg <= 1'b0;
                    oent_reg <= '{status: lrd_reg.status, hops: hinc, id: lrd_reg.id};
                    ocnt_reg <= lcnt_reg; olast_reg <= (i_reg + 1'b1 == lcnt_reg);
                    i_reg <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == lcnt_reg) ? ST_IDLE : ST_DRD;
                end
                ST_RES: if (!ovalid_reg || m_acc) begin
                    oent_reg <= '0; olast_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            // result fields for merge and insert
            if (state_reg == ST_MCMP && !i_more && !j_more) begin
                lcnt_reg <= m_reg; okind_reg <= KIND_MERGE; ochg_reg <= delta_reg;
                ocnt_reg <= m_reg;
            end
            if (state_reg == ST_IDLE && s_acc && s_tuser[1:0] == CMD_INSERT) begin
                okind_reg <= KIND_INSERT; ochg_reg <= 1'b0; ocnt_reg <= lcnt_reg;
            end
            if (state_reg == ST_IWR) begin ochg_reg <= 1'b1; ocnt_reg <= lcnt_reg + 1'b1; end
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {CntW'(ocnt_reg), ochg_reg, oent_reg.status, oent_reg.hops, oent_reg.id};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    `CHTM_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, state_reg == ST_IDLE)
    `CHTM_ASSERT_IMP(a_cnt_max, aclk, aresetn, 1'b1, lcnt_reg <= DepthC && rcnt_reg <= DepthC)
    `CHTM_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
endmodule
